@@ rtl/core/tdpb_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared constants, types and helpers for the tail-drop packet buffer.
// ----------------------------------------------------------------------------
package tdpb_pkg;

  // number of queue cells
  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int TIME_W = 32;
  localparam int PROC_W = 16;
  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  // register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_BUFFER_SIZE = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_INSERT
  } state_t;

  // control from the sequencer to the cell chain
  typedef struct packed {
    logic              expire;
    logic              shift;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] new_finish;
  } chain_ctrl_t;

  // status from the cell chain
  typedef struct packed {
    logic [DEPTH-1:0]  valid;
    logic [TIME_W-1:0] head_finish;
  } chain_stat_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [PROC_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + (TIME_W+1)'(b);
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

@@ rtl/core/tdpb_intf.sv @@
// ----------------------------------------------------------------------------
// tdpb interfaces
// Valid/ready channels for packet descriptors and scheduling results.
// ----------------------------------------------------------------------------
interface tdpb_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [tdpb_pkg::TIME_W-1:0]   arr_stamp;
  logic [tdpb_pkg::PROC_W-1:0]   svc_len;

  modport source (output valid, output arr_stamp, output svc_len, input ready);
  modport sink (input valid, input arr_stamp, input svc_len, output ready);
endinterface

interface tdpb_res_if;
  logic                          valid;
  logic                          ready;
  logic                          dropped;
  logic [tdpb_pkg::TIME_W-1:0]   svc_start;

  modport source (output valid, output dropped, output svc_start, input ready);
  modport sink (input valid, input dropped, input svc_start, output ready);
endinterface

@@ rtl/core/tail_drop_packet_buffer_scheduler.sv @@
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_scheduler
// Single-server packet buffer with tail drop, built as a row of queue cells.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  pkt      in   valid/ready      arr_stamp[31:0], svc_len[15:0]
//  res      out  valid/ready      dropped, svc_start[31:0]
//  apb      in   psel/penable     buffer_size at byte address 0
//
// per packet: retirement compare in every cell at the accept edge, then the
// full check, start time and, unless full, a one-place shift of the row.
// one result register; a waiting result does not block the next accept,
// but insert stalls while the result register is still occupied.
// reset empties the queue and sets buffer_size to 64; no clearing pass.
// ----------------------------------------------------------------------------
module tail_drop_packet_buffer_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  tdpb_pkt_if.sink                      pkt,
  tdpb_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdpb_pkg::ADDR_W-1:0]   paddr,
  input  logic [tdpb_pkg::DATA_W-1:0]   pwdata,
  output logic [tdpb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  tdpb_pkg::state_t             state;
  tdpb_pkg::state_t             state_next;
  logic [tdpb_pkg::SIZE_W-1:0]  buffer_size;
  logic [tdpb_pkg::TIME_W-1:0]  arrival;
  logic [tdpb_pkg::PROC_W-1:0]  proc;
  logic                         res_valid;
  logic                         res_dropped;
  logic [tdpb_pkg::TIME_W-1:0]  res_start;

  tdpb_pkg::chain_ctrl_t        ctrl;
  tdpb_pkg::chain_stat_t        stat;

  logic                         full;
  logic [tdpb_pkg::TIME_W-1:0]  start;
  logic [31:0]                  size_ext;
  logic [tdpb_pkg::IDX_W-1:0]   size_idx;
  logic                         load;
  logic                         accept;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tdpb_pkg::REG_BUFFER_SIZE) ?
                  tdpb_pkg::DATA_W'(buffer_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= tdpb_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == tdpb_pkg::REG_BUFFER_SIZE)) begin
      buffer_size <= pwdata[tdpb_pkg::SIZE_W-1:0];
    end
  end

  // full check: occupied cells form a prefix, so look at the last allowed cell
  assign size_ext = 32'(buffer_size);
  assign size_idx = tdpb_pkg::IDX_W'(size_ext - 32'd1);

  always_comb begin
    if (buffer_size == '0) begin
      full = 1'b1;
    end else if (size_ext >= 32'(tdpb_pkg::DEPTH)) begin
      full = stat.valid[tdpb_pkg::DEPTH-1];
    end else begin
      full = stat.valid[size_idx];
    end
  end

  assign start = stat.valid[0] ? stat.head_finish : arrival;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = pkt.valid && pkt.ready;

  always_comb begin
    state_next      = state;
    pkt.ready       = 1'b0;
    load            = 1'b0;
    ctrl.expire     = 1'b0;
    ctrl.shift      = 1'b0;
    ctrl.arrival    = pkt.arr_stamp;
    ctrl.new_finish = tdpb_pkg::sat_add(start, proc);
    unique case (state)
      tdpb_pkg::ST_IDLE: begin
        pkt.ready   = 1'b1;
        ctrl.expire = pkt.valid;
        if (pkt.valid) begin
          state_next = tdpb_pkg::ST_INSERT;
        end
      end
      tdpb_pkg::ST_INSERT: begin
        if (!res_valid || res.ready) begin
          load       = 1'b1;
          ctrl.shift = !full;
          state_next = tdpb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tdpb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arrival <= pkt.arr_stamp;
      proc    <= pkt.svc_len;
    end
  end

  tdpb_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_dropped <= full;
      res_start   <= full ? '0 : start;
    end
  end

  assign res.valid     = res_valid;
  assign res.dropped   = res_dropped;
  assign res.svc_start = res_start;

`ifndef NO_ASSERTIONS
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (stat.valid & (stat.valid + 1'b1)) == '0)
    else $error("occupied cells are not a prefix of the row");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |-> !stat.valid[tdpb_pkg::DEPTH-1])
    else $error("insert would push an entry off the end of the row");

  a_insert_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == tdpb_pkg::ST_INSERT) && !pkt.ready)
    else $error("accepted transaction not followed by insert");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.dropped) |-> (res.svc_start == '0))
    else $error("dropped result carries a nonzero start time");
`endif

endmodule

@@ rtl/core/tdpb_cell.sv @@
// ----------------------------------------------------------------------------
// tdpb_cell
// One queue slot: a finish time and an occupied flag, retired on arrival
// compare, shifted from its lower neighbor on insert.
// ----------------------------------------------------------------------------
module tdpb_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  tdpb_pkg::chain_ctrl_t       ctrl,
  input  logic                        prev_valid,
  input  logic [tdpb_pkg::TIME_W-1:0] prev_finish,
  output logic                        valid,
  output logic [tdpb_pkg::TIME_W-1:0] finish
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= prev_valid;
    end else if (ctrl.expire && valid && (finish <= ctrl.arrival)) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      finish <= prev_finish;
    end
  end

endmodule

@@ rtl/core/tdpb_chain.sv @@
// ----------------------------------------------------------------------------
// tdpb_chain
// Row of queue cells; newest entry in cell 0, oldest at the highest
// occupied cell, so occupied cells always form a prefix.
// ----------------------------------------------------------------------------
module tdpb_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  tdpb_pkg::chain_ctrl_t ctrl,
  output tdpb_pkg::chain_stat_t stat
);

  logic [tdpb_pkg::DEPTH-1:0]  valid;
  logic [tdpb_pkg::TIME_W-1:0] finish [tdpb_pkg::DEPTH];

  for (genvar i = 0; i < tdpb_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tdpb_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .prev_valid  (1'b1),
        .prev_finish (ctrl.new_finish),
        .valid       (valid[i]),
        .finish      (finish[i])
      );
    end else begin : g_body
      tdpb_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .prev_valid  (valid[i-1]),
        .prev_finish (finish[i-1]),
        .valid       (valid[i]),
        .finish      (finish[i])
      );
    end
  end

  assign stat.valid       = valid;
  assign stat.head_finish = finish[0];

endmodule
